// ===== hw/rtl/pixel_decimate_base64_encoder_top_macros.svh =====
// Assertion helpers shared by the encoder modules.
`ifndef PIXEL_DECIMATE_BASE64_ENCODER_TOP_MACROS_SVH
`define PIXEL_DECIMATE_BASE64_ENCODER_TOP_MACROS_SVH

// Checked on every clock edge outside reset.
`define PDE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PDE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/pde_pkg.sv =====
`timescale 1ns / 1ps

package pde_pkg;

   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_LOG2     = 2'd2;

   localparam logic [CSR_DATA_W-1:0] SOURCE_WIDTH_RESET  = 11'd640;
   localparam logic [CSR_DATA_W-1:0] SOURCE_HEIGHT_RESET = 11'd480;
   localparam logic [1:0]            STEP_LOG2_RESET     = 2'd1;

   localparam logic [1:0] STEP_LOG2_MAX = 2'd2;

   localparam int MAX_CHARS    = 8;
   localparam int CHAR_COUNT_W = 4;

   localparam logic [CHAR_COUNT_W-1:0] GROUP_CHARS = 4'd4;

   localparam logic [7:0] PAD_CHAR   = 8'h3D;
   localparam logic [7:0] PLUS_CHAR  = 8'h2B;
   localparam logic [7:0] SLASH_CHAR = 8'h2F;

   typedef struct packed {
      logic [15:0] pend_bytes;
      logic [1:0]  pend_count;
      logic        row_done;
      logic        frame_last;
   } pack_req_type;

   typedef struct packed {
      logic [MAX_CHARS-1:0][7:0] chars;
      logic [CHAR_COUNT_W-1:0]   count;
      logic                      row_end;
      logic                      frame_end;
      logic [15:0]               pend_bytes;
      logic [1:0]                pend_count;
   } pack_rsp_type;

   function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
      logic [7:0] c;
      c = 8'(v);
      if (v < 6'd26) begin
         return c + 8'h41;
      end else if (v < 6'd52) begin
         return c + 8'd71;
      end else if (v < 6'd62) begin
         return c - 8'd4;
      end else if (v == 6'd62) begin
         return PLUS_CHAR;
      end
      return SLASH_CHAR;
   endfunction

endpackage

// ===== hw/rtl/pde_pack.sv =====
`timescale 1ns / 1ps

module pde_pack (
   input  logic                  [15:0] pixel_value,
   input  pde_pkg::pack_req_type        pack_req,
   output pde_pkg::pack_rsp_type        pack_rsp
);

   logic [7:0]  b0;
   logic [7:0]  b1;
   logic [7:0]  pa;
   logic [7:0]  pb;
   logic        full;
   logic        flush;
   logic [23:0] grp;
   logic [23:0] fl;
   logic [15:0] np;
   logic [1:0]  nc;
   logic [3:0][7:0] gchars;
   logic [3:0][7:0] fchars;

   always_comb begin
      b0 = pixel_value[7:0];
      b1 = pixel_value[15:8];
      pa = pack_req.pend_bytes[15:8];
      pb = pack_req.pend_bytes[7:0];
      full = 1'b0;
      grp = 24'h000000;
      np = 16'h0000;
      nc = 2'd0;
      case (pack_req.pend_count)
         2'd0: begin
            np = {b0, b1};
            nc = 2'd2;
         end
         2'd1: begin
            full = 1'b1;
            grp = {pa, b0, b1};
         end
         default: begin
            full = 1'b1;
            grp = {pa, pb, b0};
            np = {b1, 8'h00};
            nc = 2'd1;
         end
      endcase

      gchars[0] = pde_pkg::sextet_to_char(grp[23:18]);
      gchars[1] = pde_pkg::sextet_to_char(grp[17:12]);
      gchars[2] = pde_pkg::sextet_to_char(grp[11:6]);
      gchars[3] = pde_pkg::sextet_to_char(grp[5:0]);

      fl = {np, 8'h00};
      fchars[0] = pde_pkg::sextet_to_char(fl[23:18]);
      fchars[1] = pde_pkg::sextet_to_char(fl[17:12]);
      fchars[2] = (nc == 2'd2) ? pde_pkg::sextet_to_char(fl[11:6]) : pde_pkg::PAD_CHAR;
      fchars[3] = pde_pkg::PAD_CHAR;
      flush = pack_req.row_done && (nc != 2'd0);

      if (full) begin
         pack_rsp.chars = {fchars, gchars};
      end else begin
         pack_rsp.chars = {{4{pde_pkg::PAD_CHAR}}, fchars};
      end
      pack_rsp.count = (full ? pde_pkg::GROUP_CHARS : 4'd0)
                     + (flush ? pde_pkg::GROUP_CHARS : 4'd0);
      pack_rsp.row_end = pack_req.row_done;
      pack_rsp.frame_end = pack_req.row_done && pack_req.frame_last;
      pack_rsp.pend_bytes = pack_req.row_done ? 16'h0000 : np;
      pack_rsp.pend_count = pack_req.row_done ? 2'd0 : nc;
   end

endmodule

// ===== hw/rtl/pde_ctrl.sv =====
`timescale 1ns / 1ps
`include "pixel_decimate_base64_encoder_top_macros.svh"

module pde_ctrl #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [pde_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pde_pkg::CSR_DATA_W-1:0]        csr_write_data,
   input  logic                                  req_accept,
   input  pde_pkg::pack_rsp_type                 pack_rsp,
   output logic                                  keep_now,
   output pde_pkg::pack_req_type                 pack_req
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   logic [pde_pkg::CSR_DATA_W-1:0] src_w_ff, src_w_in;
   logic [pde_pkg::CSR_DATA_W-1:0] src_h_ff, src_h_in;
   logic [1:0]                     step_ff, step_in;
   logic [CW-1:0]                  col_ff, col_in;
   logic [RW-1:0]                  row_ff, row_in;
   logic [WW-1:0]                  kept_ff, kept_in;
   logic [15:0]                    pend_bytes_ff, pend_bytes_in;
   logic [1:0]                     pend_count_ff, pend_count_in;

   logic [31:0] w_raw;
   logic [31:0] h_raw;
   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [1:0]    k;
   logic [31:0]   mask;
   logic [WW-1:0] out_w;
   logic [HW-1:0] out_h;
   logic [RW-1:0] row_idx;
   logic          row_kept;
   logic          row_done;
   logic          col_wrap;
   logic          row_wrap;

   always_comb begin
      w_raw = 32'(src_w_ff);
      h_raw = 32'(src_h_ff);
      if (w_raw == 32'd0) begin
         w_eff = WW'(1);
      end else if (w_raw > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(w_raw);
      end
      if (h_raw == 32'd0) begin
         h_eff = HW'(1);
      end else if (h_raw > 32'(MAX_HEIGHT)) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(h_raw);
      end
      k = (step_ff > pde_pkg::STEP_LOG2_MAX) ? pde_pkg::STEP_LOG2_MAX : step_ff;
      mask = (32'd1 << k) - 32'd1;
      out_w = w_eff >> k;
      out_h = h_eff >> k;
      row_idx = row_ff >> k;

      row_kept = ((32'(row_ff) & mask) == 32'd0) && (32'(row_idx) < 32'(out_h));
      keep_now = row_kept && ((32'(col_ff) & mask) == 32'd0)
               && (32'(kept_ff) < 32'(out_w));
      row_done = keep_now && ((32'(kept_ff) + 32'd1) >= 32'(out_w));
      col_wrap = (32'(col_ff) + 32'd1) >= 32'(w_eff);
      row_wrap = (32'(row_ff) + 32'd1) >= 32'(h_eff);

      pack_req.pend_bytes = pend_bytes_ff;
      pack_req.pend_count = pend_count_ff;
      pack_req.row_done = row_done;
      pack_req.frame_last = (32'(row_idx) + 32'd1) >= 32'(out_h);
   end

   always_comb begin
      src_w_in = src_w_ff;
      src_h_in = src_h_ff;
      step_in = step_ff;
      if (csr_write_enable) begin
         case (csr_index)
            pde_pkg::CSR_SOURCE_WIDTH:  src_w_in = csr_write_data;
            pde_pkg::CSR_SOURCE_HEIGHT: src_h_in = csr_write_data;
            pde_pkg::CSR_STEP_LOG2:     step_in = csr_write_data[1:0];
            default: ;
         endcase
      end

      col_in = col_ff;
      row_in = row_ff;
      kept_in = kept_ff;
      pend_bytes_in = pend_bytes_ff;
      pend_count_in = pend_count_ff;
      if (req_accept) begin
         if (keep_now) begin
            kept_in = kept_ff + WW'(1);
            pend_bytes_in = pack_rsp.pend_bytes;
            pend_count_in = pack_rsp.pend_count;
         end
         if (col_wrap) begin
            col_in = '0;
            kept_in = '0;
            pend_bytes_in = 16'h0000;
            pend_count_in = 2'd0;
            row_in = row_wrap ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= pde_pkg::SOURCE_WIDTH_RESET;
         src_h_ff <= pde_pkg::SOURCE_HEIGHT_RESET;
         step_ff <= pde_pkg::STEP_LOG2_RESET;
         col_ff <= '0;
         row_ff <= '0;
         kept_ff <= '0;
         pend_bytes_ff <= 16'h0000;
         pend_count_ff <= 2'd0;
      end else begin
         src_w_ff <= src_w_in;
         src_h_ff <= src_h_in;
         step_ff <= step_in;
         col_ff <= col_in;
         row_ff <= row_in;
         kept_ff <= kept_in;
         pend_bytes_ff <= pend_bytes_in;
         pend_count_ff <= pend_count_in;
      end
   end

   `PDE_ASSERT(pend_count_range, pend_count_ff != 2'd3, "pending byte count out of range")
   `PDE_ASSERT(row_wrap_clears, (req_accept && col_wrap) |=> (kept_ff == '0 && pend_count_ff == 2'd0), "row end did not clear pending state")

endmodule

// ===== hw/rtl/pde_serial.sv =====
`timescale 1ns / 1ps
`include "pixel_decimate_base64_encoder_top_macros.svh"

module pde_serial (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  pde_pkg::pack_rsp_type pack_rsp,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_ascii_char,
   output logic                  rsp_last_of_item,
   output logic                  rsp_row_end,
   output logic                  rsp_frame_end,
   output logic                  free
);

   logic [pde_pkg::MAX_CHARS-1:0][7:0] chars_ff, chars_in;
   logic [pde_pkg::CHAR_COUNT_W-1:0]   rem_ff, rem_in;
   logic                               row_flag_ff, row_flag_in;
   logic                               frame_flag_ff, frame_flag_in;
   logic                               busy;
   logic                               last;
   logic                               take;
   logic                               stalled;

   always_comb begin
      busy = rem_ff != '0;
      last = rem_ff == pde_pkg::CHAR_COUNT_W'(1);
      rsp_valid = busy && !reset;
      take = rsp_valid && rsp_ready;
      free = !busy || (rsp_ready && last);
      stalled = busy && !rsp_ready && !load;
      rsp_ascii_char = chars_ff[0];
      rsp_last_of_item = last;
      rsp_row_end = last && row_flag_ff;
      rsp_frame_end = last && frame_flag_ff;

      chars_in = chars_ff;
      rem_in = rem_ff;
      row_flag_in = row_flag_ff;
      frame_flag_in = frame_flag_ff;
      if (take) begin
         chars_in = {8'h00, chars_ff[pde_pkg::MAX_CHARS-1:1]};
         rem_in = rem_ff - pde_pkg::CHAR_COUNT_W'(1);
      end
      if (load) begin
         chars_in = pack_rsp.chars;
         rem_in = pack_rsp.count;
         row_flag_in = pack_rsp.row_end;
         frame_flag_in = pack_rsp.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
      chars_ff <= chars_in;
      row_flag_ff <= row_flag_in;
      frame_flag_ff <= frame_flag_in;
   end

   `PDE_ASSERT_ALWAYS(reset_empties, reset |=> !busy, "character buffer not empty after reset")
   `PDE_ASSERT(load_group_size, load |=> rem_ff[1:0] == 2'd0, "load of a partial group")
   `PDE_ASSERT(no_overwrite, load |-> free, "load over undelivered characters")
   `PDE_ASSERT(stall_holds, stalled |=> $stable({rem_ff, chars_ff}), "stalled buffer changed")

endmodule

// ===== hw/rtl/pixel_decimate_base64_encoder_top.sv =====
`timescale 1ns / 1ps
// Decimating base64 encoder for RGB565 frames.
// The req channel takes one 16-bit pixel per transaction in raster order. The
// block keeps every 2^step_log2-th pixel of every 2^step_log2-th row and sends
// its two bytes, low byte first, into a base64 stream that restarts on every
// output row. The rsp channel carries one character per transaction, with
// flags on the last character of a pixel, of an output row and of a frame.
// A kept pixel yields 0, 4 or 8 characters; dropped pixels yield none.
// Latency: the first character of a pixel is offered the cycle after the
// pixel is accepted. Throughput is one character per cycle on rsp while the
// receiver is ready, set by the single character output of the group buffer.
// Dropped pixels are accepted every cycle, even while characters of an earlier
// pixel are still waiting.
// A kept pixel is taken once the previous pixel's last character leaves.
// If the receiver stalls, the character on rsp holds and kept pixels wait.
// The csr port writes source_width, source_height and step_log2; write it
// only while the block is idle. Synchronous reset restores the default
// 640x480 frame with step 1, clears the counters and drops queued characters.

module pixel_decimate_base64_encoder_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [15:0]                     req_pixel_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_ascii_char,
   output logic                            rsp_last_of_item,
   output logic                            rsp_row_end,
   output logic                            rsp_frame_end,
   input  logic                            csr_write_enable,
   input  logic [pde_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pde_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   pde_pkg::pack_req_type pack_req;
   pde_pkg::pack_rsp_type pack_rsp;
   logic                  keep_now;
   logic                  free;
   logic                  req_accept;
   logic                  load;

   assign req_ready = !reset && (free || !keep_now);
   assign req_accept = req_valid && req_ready;
   assign load = req_accept && keep_now;

   pde_ctrl #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_accept(req_accept),
      .pack_rsp(pack_rsp),
      .keep_now(keep_now),
      .pack_req(pack_req)
   );

   pde_pack u_pack (
      .pixel_value(req_pixel_value),
      .pack_req(pack_req),
      .pack_rsp(pack_rsp)
   );

   pde_serial u_serial (
      .clock(clock),
      .reset(reset),
      .load(load),
      .pack_rsp(pack_rsp),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_ascii_char(rsp_ascii_char),
      .rsp_last_of_item(rsp_last_of_item),
      .rsp_row_end(rsp_row_end),
      .rsp_frame_end(rsp_frame_end),
      .free(free)
   );

endmodule
